// ----- rtl/tcls_pkg.sv -----
// ----------------------------------------------------------------------------
// tcls_pkg
// Types, constants and helpers for the two-way load/store cache.
// ----------------------------------------------------------------------------
`default_nettype none

package tcls_pkg;

	localparam int SET_COUNT    = 8;
	localparam int MEMORY_WORDS = 128;
	localparam int WAYS         = 2;
	localparam int REG_COUNT    = 8;

	localparam int ADDR_W   = 7;
	localparam int REG_W    = 3;
	localparam int DATA_W   = 32;
	localparam int SET_W    = $clog2(SET_COUNT);
	localparam int TAG_W    = ADDR_W - SET_W;
	localparam int MEM_AW   = $clog2(MEMORY_WORDS);
	localparam int WAY_W    = $clog2(WAYS);

	localparam logic [DATA_W-1:0] MEM_INIT_OFFSET = DATA_W'(5);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_STORE = 1'b1;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] word_address;
		logic [REG_W-1:0]  target_reg;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              way_used;
		logic              wrote_back;
		logic [DATA_W-1:0] load_value;
	} rsp_t;

	// word address to memory index, wrapping at the memory size
	function automatic logic [MEM_AW-1:0] mem_idx(input logic [ADDR_W-1:0] a);
		logic [ADDR_W+MEM_AW-1:0] w;
		w = {{MEM_AW{1'b0}}, a};
		return w[MEM_AW-1:0];
	endfunction

	// contents of a memory word never written since reset
	function automatic logic [DATA_W-1:0] mem_init(input logic [MEM_AW-1:0] i);
		return DATA_W'(i) + MEM_INIT_OFFSET;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tcls_ram.sv -----
// ----------------------------------------------------------------------------
// tcls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/two_way_cache_load_store.sv -----
// ----------------------------------------------------------------------------
// two_way_cache_load_store
// Register file, 2-way LRU cache and word memory serving one load or store
// per request.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready/req) carries op, word address and
// target register. Response channel (rsp_valid/rsp_ready/rsp) returns hit,
// way used, write-back flag and the loaded value, one response per request,
// in order.
// Requests pass the lookup stage, then the output register. Throughput:
// one request per cycle unless stalled; the memory's one read port (read
// issued at acceptance) and one write port (write-back or store miss) set
// that figure. A read that meets a write to the same word is forwarded.
// Reset: cache lines invalid, LRU points at way 0, registers zero. Memory
// words carry a written flag, so an unwritten word reads as its address
// plus five; no clearing pass is needed and requests are taken at once.
// When rsp_ready is low a response waits in the output register; one more
// request is held in the lookup stage, then req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module two_way_cache_load_store
	import tcls_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output      logic req_ready,
	input  wire req_t req,
	output      logic rsp_valid,
	input  wire logic rsp_ready,
	output      rsp_t rsp
);

	logic              valid_s1;
	req_t              req_s1;
	logic              mvld_s1;
	logic              fwd_s1;
	logic [DATA_W-1:0] fwd_data_s1;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [DATA_W-1:0]       rf_q    [REG_COUNT];
	logic [WAYS-1:0]         lvld_q  [SET_COUNT];
	logic [TAG_W-1:0]        ltag_q  [SET_COUNT][WAYS];
	logic [DATA_W-1:0]       ldata_q [SET_COUNT][WAYS];
	logic [SET_COUNT-1:0]    lru_q;
	logic [MEMORY_WORDS-1:0] mvld_q;

	logic              req_fire;
	logic              s1_fire;
	logic [DATA_W-1:0] ram_rdata;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [MEM_AW-1:0] req_idx;

	logic [SET_W-1:0]  set_c;
	logic [TAG_W-1:0]  tag_c;
	logic              hit0_c;
	logic              hit1_c;
	logic              hit_c;
	logic              hway_c;
	logic              victim_c;
	logic              is_store_c;
	logic              way_c;
	logic              wrote_c;
	logic              fill_c;
	logic [DATA_W-1:0] value_c;
	logic [DATA_W-1:0] mem_rd_c;
	logic [DATA_W-1:0] reg_rd_c;
	logic              mem_we_c;
	logic [ADDR_W-1:0] mem_waddr_c;
	logic [DATA_W-1:0] mem_wdata_c;

	assign s1_fire   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || s1_fire;
	assign req_fire  = req_valid && req_ready;
	assign req_idx   = mem_idx(req.word_address);
	assign mem_we    = s1_fire && mem_we_c;
	assign mem_waddr = mem_idx(mem_waddr_c);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	tcls_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MEMORY_WORDS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata_c),
		.re    (req_fire),
		.raddr (req_idx),
		.rdata (ram_rdata)
	);

	always_comb begin
		set_c      = req_s1.word_address[SET_W-1:0];
		tag_c      = req_s1.word_address[ADDR_W-1:SET_W];
		hit0_c     = lvld_q[set_c][0] && (ltag_q[set_c][0] == tag_c);
		hit1_c     = lvld_q[set_c][1] && (ltag_q[set_c][1] == tag_c);
		hit_c      = hit0_c || hit1_c;
		hway_c     = !hit0_c;
		victim_c   = lru_q[set_c];
		is_store_c = (req_s1.op == OP_STORE);
		reg_rd_c   = rf_q[req_s1.target_reg];
		if (fwd_s1) begin
			mem_rd_c = fwd_data_s1;
		end else if (mvld_s1) begin
			mem_rd_c = ram_rdata;
		end else begin
			mem_rd_c = mem_init(mem_idx(req_s1.word_address));
		end

		way_c       = 1'b0;
		wrote_c     = 1'b0;
		fill_c      = 1'b0;
		value_c     = '0;
		mem_we_c    = 1'b0;
		mem_waddr_c = req_s1.word_address;
		mem_wdata_c = reg_rd_c;
		if (!is_store_c) begin
			if (hit_c) begin
				way_c   = hway_c;
				value_c = ldata_q[set_c][hway_c];
			end else begin
				way_c   = victim_c;
				fill_c  = 1'b1;
				value_c = mem_rd_c;
				if (lvld_q[set_c][victim_c]) begin
					wrote_c     = 1'b1;
					mem_we_c    = 1'b1;
					mem_waddr_c = {ltag_q[set_c][victim_c], set_c};
					mem_wdata_c = ldata_q[set_c][victim_c];
				end
			end
		end else if (hit_c) begin
			way_c = hway_c;
		end else begin
			mem_we_c = 1'b1;
		end
	end

	// lookup stage and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= mem_we && (mem_waddr == req_idx);
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1      <= req;
			mvld_s1     <= mvld_q[req_idx];
			fwd_data_s1 <= mem_wdata_c;
		end
		if (s1_fire) begin
			rsp_q.hit        <= hit_c;
			rsp_q.way_used   <= way_c;
			rsp_q.wrote_back <= wrote_c;
			rsp_q.load_value <= value_c;
		end
	end

	// architectural state with reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				rf_q[i] <= '0;
			end
			for (int i = 0; i < SET_COUNT; i++) begin
				lvld_q[i] <= '0;
			end
			lru_q  <= '0;
			mvld_q <= '0;
		end else if (s1_fire) begin
			if (mem_we_c) begin
				mvld_q[mem_waddr] <= 1'b1;
			end
			if (!is_store_c) begin
				rf_q[req_s1.target_reg] <= value_c;
				lru_q[set_c]            <= !way_c;
				lvld_q[set_c][way_c]    <= 1'b1;
			end else if (hit_c) begin
				lru_q[set_c] <= !way_c;
			end
		end
	end

	// line tags and data
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			if (fill_c) begin
				ltag_q[set_c][way_c]  <= tag_c;
				ldata_q[set_c][way_c] <= mem_rd_c;
			end else if (is_store_c && hit_c) begin
				ldata_q[set_c][way_c] <= reg_rd_c;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_double_hit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(hit0_c && hit1_c))
		else $error("address hits in both ways");

	a_lru_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !is_store_c) |=> (lru_q[$past(set_c)] != $past(way_c)))
		else $error("LRU not pointing away from the way just loaded");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_fire) |=> (valid_s1 && $stable(req_s1)))
		else $error("lookup stage lost a stalled request");
`endif

endmodule

`default_nettype wire
